>>> rtl/rate_loop_motor_mixer_top_assert.svh
// Assertion macros used by the rate loop motor mixer top level.
`ifndef RATE_LOOP_MOTOR_MIXER_TOP_ASSERT_SVH
`define RATE_LOOP_MOTOR_MIXER_TOP_ASSERT_SVH

// Checks that a condition implies another in the same cycle.
`define RLMM_ASSERT_SAME(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("rlmm: same-cycle check failed");

// Checks that a condition implies another in the following cycle.
`define RLMM_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("rlmm: next-cycle check failed");

`endif

>>> rtl/rlmm_pkg.sv
// Package with shared types, register indexes and saturation helper for the mixer.
`default_nettype none

package rlmm_pkg;

  localparam int NumRegs = 8;
  localparam int RegIdxW = 3;
  localparam int AddrW   = 5;
  localparam int Latency = 6;

  localparam logic [15:0] CfgReset = 16'd256;

  localparam logic [RegIdxW-1:0] REG_ROLL_GAIN     = 3'd0;
  localparam logic [RegIdxW-1:0] REG_PITCH_GAIN    = 3'd1;
  localparam logic [RegIdxW-1:0] REG_YAW_GAIN      = 3'd2;
  localparam logic [RegIdxW-1:0] REG_INERTIA_ROLL  = 3'd3;
  localparam logic [RegIdxW-1:0] REG_INERTIA_PITCH = 3'd4;
  localparam logic [RegIdxW-1:0] REG_INERTIA_YAW   = 3'd5;
  localparam logic [RegIdxW-1:0] REG_INV_ARM       = 3'd6;
  localparam logic [RegIdxW-1:0] REG_INV_DRAG      = 3'd7;

  typedef struct packed {
    logic               sat;
    logic signed [15:0] val;
  } sat_t;

  function automatic sat_t sat16(input logic signed [24:0] v);
    sat_t r;
    if (v > 25'sd32767) begin
      r.sat = 1'b1;
      r.val = 16'sh7fff;
    end else if (v < -25'sd32768) begin
      r.sat = 1'b1;
      r.val = 16'sh8000;
    end else begin
      r.sat = 1'b0;
      r.val = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rlmm_axis.sv
// One axis lane: rate error, gain, inertia and mixer factor with rounding and clipping.
`default_nettype none

module rlmm_axis (
  input  wire logic               clk,
  input  wire logic signed [15:0] meas,
  input  wire logic signed [15:0] target,
  input  wire logic [15:0]        gain,
  input  wire logic [15:0]        inertia,
  input  wire logic [15:0]        factor,
  input  wire logic               neg,
  output rlmm_pkg::sat_t          term
);
  import rlmm_pkg::*;

  logic signed [16:0] err;
  logic signed [32:0] prod_gain;
  logic signed [31:0] prod_inertia;
  logic signed [31:0] prod_factor;
  logic               sat3;
  logic               sat4;

  logic signed [16:0] gain_s;
  logic signed [16:0] inertia_s;
  logic signed [16:0] factor_s;
  logic signed [32:0] gain_rnd;
  logic signed [31:0] inertia_rnd;
  logic signed [31:0] factor_sgn;
  logic signed [31:0] factor_rnd;
  sat_t               accel;
  sat_t               moment;
  sat_t               term_next;

  assign gain_s    = {1'b0, gain};
  assign inertia_s = {1'b0, inertia};
  assign factor_s  = {1'b0, factor};

  assign gain_rnd    = prod_gain + 33'sd128;
  assign accel       = sat16(gain_rnd[32:8]);
  assign inertia_rnd = prod_inertia + 32'sd2048;
  assign moment      = sat16({{5{inertia_rnd[31]}}, inertia_rnd[31:12]});
  assign factor_sgn  = neg ? -prod_factor : prod_factor;
  assign factor_rnd  = factor_sgn + 32'sd128;

  always_comb begin
    term_next     = sat16({factor_rnd[31], factor_rnd[31:8]});
    term_next.sat = term_next.sat | sat4;
  end

  always_ff @(posedge clk) begin
    err          <= 17'(target) - 17'(meas);
    prod_gain    <= err * gain_s;
    prod_inertia <= accel.val * inertia_s;
    sat3         <= accel.sat;
    prod_factor  <= moment.val * factor_s;
    sat4         <= sat3 | moment.sat;
    term         <= term_next;
  end

endmodule

`default_nettype wire

>>> rtl/rate_loop_motor_mixer_top.sv
// Top level of the body rate P controller and X-frame motor mixer.
//
// Channel   Signals                                   Handshake
// config    psel penable pwrite paddr pwdata prdata   APB, pready always high
// input     start busy + seven rate and thrust words  taken when start && !busy
// result    done + four motor thrusts, saturated      one-cycle strobe, no stall
//
// A word is taken every cycle and busy stays low.
// Each word passes the lane pipeline registers: error, gain multiply, inertia multiply,
// factor multiply, factor rounding, then the four-way mix into the output registers.
// Reset clears the valid bits and sets all registers to 256 (1.0; inertias 1/16).
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none

module rate_loop_motor_mixer_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rlmm_pkg::AddrW-1:0]   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [15:0]           roll_rate,
  input  wire logic signed [15:0]           pitch_rate,
  input  wire logic signed [15:0]           yaw_rate,
  input  wire logic signed [15:0]           roll_rate_target,
  input  wire logic signed [15:0]           pitch_rate_target,
  input  wire logic signed [15:0]           yaw_rate_target,
  input  wire logic signed [15:0]           collective_thrust,
  output logic                              done,
  output logic signed [15:0]                thrust_front_left,
  output logic signed [15:0]                thrust_front_right,
  output logic signed [15:0]                thrust_rear_left,
  output logic signed [15:0]                thrust_rear_right,
  output logic                              saturated
);
  import rlmm_pkg::*;

  logic [15:0]        cfg [NumRegs];
  logic [Latency-2:0] valid;
  logic signed [15:0] coll [Latency-1];

  logic [RegIdxW-1:0] reg_idx;
  logic               cfg_write;
  sat_t               t_roll;
  sat_t               t_pitch;
  sat_t               t_yaw;
  logic signed [18:0] sum_fl;
  logic signed [18:0] sum_fr;
  logic signed [18:0] sum_rl;
  logic signed [18:0] sum_rr;
  sat_t               m_fl;
  sat_t               m_fr;
  sat_t               m_rl;
  sat_t               m_rr;

  assign pready    = 1'b1;
  assign busy      = 1'b0;
  assign reg_idx   = paddr[AddrW-1:2];
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = {16'd0, cfg[reg_idx]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) begin
        cfg[i] <= CfgReset;
      end
    end else if (cfg_write) begin
      cfg[reg_idx] <= pwdata[15:0];
    end
  end

  rlmm_axis u_roll (
    .clk     (clk),
    .meas    (roll_rate),
    .target  (roll_rate_target),
    .gain    (cfg[REG_ROLL_GAIN]),
    .inertia (cfg[REG_INERTIA_ROLL]),
    .factor  (cfg[REG_INV_ARM]),
    .neg     (1'b0),
    .term    (t_roll)
  );

  rlmm_axis u_pitch (
    .clk     (clk),
    .meas    (pitch_rate),
    .target  (pitch_rate_target),
    .gain    (cfg[REG_PITCH_GAIN]),
    .inertia (cfg[REG_INERTIA_PITCH]),
    .factor  (cfg[REG_INV_ARM]),
    .neg     (1'b0),
    .term    (t_pitch)
  );

  rlmm_axis u_yaw (
    .clk     (clk),
    .meas    (yaw_rate),
    .target  (yaw_rate_target),
    .gain    (cfg[REG_YAW_GAIN]),
    .inertia (cfg[REG_INERTIA_YAW]),
    .factor  (cfg[REG_INV_DRAG]),
    .neg     (1'b1),
    .term    (t_yaw)
  );

  assign sum_fl = 19'(t_roll.val) + 19'(t_pitch.val) + 19'(t_yaw.val)
                + 19'(coll[Latency-2]) + 19'sd2;
  assign sum_fr = -19'(t_roll.val) + 19'(t_pitch.val) - 19'(t_yaw.val)
                + 19'(coll[Latency-2]) + 19'sd2;
  assign sum_rl = 19'(t_roll.val) - 19'(t_pitch.val) - 19'(t_yaw.val)
                + 19'(coll[Latency-2]) + 19'sd2;
  assign sum_rr = -19'(t_roll.val) - 19'(t_pitch.val) + 19'(t_yaw.val)
                + 19'(coll[Latency-2]) + 19'sd2;

  assign m_fl = sat16({{8{sum_fl[18]}}, sum_fl[18:2]});
  assign m_fr = sat16({{8{sum_fr[18]}}, sum_fr[18:2]});
  assign m_rl = sat16({{8{sum_rl[18]}}, sum_rl[18:2]});
  assign m_rr = sat16({{8{sum_rr[18]}}, sum_rr[18:2]});

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      done  <= 1'b0;
    end else begin
      valid <= {valid[Latency-3:0], start && !busy};
      done  <= valid[Latency-2];
    end
  end

  always_ff @(posedge clk) begin
    coll[0] <= collective_thrust;
    for (int i = 1; i < Latency - 1; i++) begin
      coll[i] <= coll[i-1];
    end
    thrust_front_left  <= m_fl.val;
    thrust_front_right <= m_fr.val;
    thrust_rear_left   <= m_rl.val;
    thrust_rear_right  <= m_rr.val;
    saturated          <= t_roll.sat | t_pitch.sat | t_yaw.sat
                        | m_fl.sat | m_fr.sat | m_rl.sat | m_rr.sat;
  end

`include "rate_loop_motor_mixer_top_assert.svh"

  `RLMM_ASSERT_NEXT(a_last_stage_strobes, clk, rst, valid[Latency-2], done)
  `RLMM_ASSERT_SAME(a_done_has_start, clk, rst, done, $past(start, Latency))
  `RLMM_ASSERT_NEXT(a_quiet_pipe, clk, rst, !start && valid == '0, !done)

endmodule

`default_nettype wire
